// ===== src/imuafp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the IMU angle frame parser.
// No dependencies; used by imuafp_cell and imu_angle_frame_parser_core.
package imuafp_pkg;

    localparam int FRAME_LEN = 37;
    localparam int NUM_CELLS = FRAME_LEN - 1;
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);

    typedef logic [7:0] t_byte;

    localparam t_byte       HDR_BYTE  = 8'hAA;
    localparam t_byte       SYNC_BYTE = 8'h55;
    localparam logic [15:0] CMD_ANGLE = 16'h0003;

    localparam int SYNC_POS  = 1;
    localparam int CMD_POS   = 2;
    localparam int RATE_POS  = 6;
    localparam int FLOAT_POS = 8;
    localparam int NUM_FLOAT = 7;

endpackage

// ===== src/imuafp_cell.sv =====
`timescale 1ns / 1ps
// One byte cell of the frame shift chain.
// Depends on imuafp_pkg for the byte type.
module imuafp_cell (
    input  logic               i_clk,
    input  logic               i_shift,
    input  imuafp_pkg::t_byte  i_byte,
    output imuafp_pkg::t_byte  o_byte
);

    imuafp_pkg::t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ===== src/imu_angle_frame_parser_core.sv =====
`timescale 1ns / 1ps
// Top level of the IMU angle frame parser: byte chain, framing control, output word.
// Depends on imuafp_pkg and imuafp_cell.
//
//   Channel   Handshake                Payload
//   input     i_valid / o_stall        i_rx_byte
//   output    o_valid / i_stall        o_rate, o_roll_bits .. o_quat_z_bits
//
// One byte is taken every cycle while o_stall is low; the frame sits in a chain
// of byte cells that all shift together, so decode needs no indexed memory.
// The output word is registered and appears the cycle after the last frame byte.
// Input is stalled only when a frame's last byte waits while the output is held.
// Reset is synchronous and active low and clears the phase, count and valid flag.
module imu_angle_frame_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_rate,
    output logic [31:0] o_roll_bits,
    output logic [31:0] o_pitch_bits,
    output logic [31:0] o_yaw_bits,
    output logic [31:0] o_quat_w_bits,
    output logic [31:0] o_quat_x_bits,
    output logic [31:0] o_quat_y_bits,
    output logic [31:0] o_quat_z_bits
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RECV = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam logic [imuafp_pkg::CNT_W-1:0] LAST_CNT =
        imuafp_pkg::CNT_W'(imuafp_pkg::FRAME_LEN - 1);

    logic [1:0]                    r_phase, n_phase;
    logic [imuafp_pkg::CNT_W-1:0]  r_count, n_count;
    logic                          r_out_valid, n_out_valid;
    logic [15:0]                   r_rate;
    logic [31:0]                   r_float [imuafp_pkg::NUM_FLOAT];

    imuafp_pkg::t_byte w_cell [imuafp_pkg::NUM_CELLS];
    imuafp_pkg::t_byte w_frame [imuafp_pkg::FRAME_LEN];
    logic              w_accept;
    logic              w_last;
    logic              w_shift;
    logic              w_ok;
    logic              w_load;

    assign w_last   = (r_phase == PH_RECV) && (r_count >= LAST_CNT);
    assign o_stall  = r_out_valid && i_stall && w_last;
    assign w_accept = i_valid && !o_stall;
    assign w_shift  = w_accept &&
                      ((r_phase == PH_RECV) ||
                       ((r_phase != PH_DONE) && (i_rx_byte == imuafp_pkg::HDR_BYTE)));

    genvar g;
    generate
        for (g = 0; g < imuafp_pkg::NUM_CELLS; g++) begin : g_chain
            if (g == 0) begin : g_head
                imuafp_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_byte  (i_rx_byte),
                    .o_byte  (w_cell[g])
                );
            end else begin : g_body
                imuafp_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_byte  (w_cell[g-1]),
                    .o_byte  (w_cell[g])
                );
            end
            assign w_frame[imuafp_pkg::NUM_CELLS - 1 - g] = w_cell[g];
        end
    endgenerate

    assign w_frame[imuafp_pkg::FRAME_LEN - 1] = i_rx_byte;

    assign w_ok = (w_frame[0] == imuafp_pkg::HDR_BYTE) &&
                  (w_frame[imuafp_pkg::SYNC_POS] == imuafp_pkg::SYNC_BYTE) &&
                  ({w_frame[imuafp_pkg::CMD_POS + 1], w_frame[imuafp_pkg::CMD_POS]}
                   == imuafp_pkg::CMD_ANGLE);

    assign w_load = w_accept && w_last && w_ok;

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        if (w_accept) begin
            case (r_phase)
                PH_RECV: begin
                    if (w_last) begin
                        n_count = '0;
                        n_phase = w_ok ? PH_DONE : PH_IDLE;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_rx_byte == imuafp_pkg::HDR_BYTE) begin
                        n_count = imuafp_pkg::CNT_W'(1);
                        n_phase = PH_RECV;
                    end
                end
            endcase
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rate <= {w_frame[imuafp_pkg::RATE_POS + 1], w_frame[imuafp_pkg::RATE_POS]};
            for (int k = 0; k < imuafp_pkg::NUM_FLOAT; k++) begin
                r_float[k] <= {w_frame[imuafp_pkg::FLOAT_POS + 4*k + 3],
                               w_frame[imuafp_pkg::FLOAT_POS + 4*k + 2],
                               w_frame[imuafp_pkg::FLOAT_POS + 4*k + 1],
                               w_frame[imuafp_pkg::FLOAT_POS + 4*k]};
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_rate        = r_rate;
    assign o_roll_bits   = r_float[0];
    assign o_pitch_bits  = r_float[1];
    assign o_yaw_bits    = r_float[2];
    assign o_quat_w_bits = r_float[3];
    assign o_quat_x_bits = r_float[4];
    assign o_quat_y_bits = r_float[5];
    assign o_quat_z_bits = r_float[6];

`ifndef SYNTHESIS
    a_rose_after_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_phase) == PH_RECV)
        else $error("Output word appeared without a frame in progress.");

    a_rose_enters_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> r_phase == PH_DONE)
        else $error("Accepted frame did not move the phase to done.");

    a_recv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RECV |-> (r_count != '0) && (r_count <= LAST_CNT))
        else $error("Byte count out of range while receiving.");

    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_RECV |-> r_count == '0)
        else $error("Byte count not cleared outside a frame.");
`endif

endmodule
